// ----- design/alpha8_blend_rgb565_be_assert.svh -----
// Assertion macros for the alpha8_blend_rgb565_be checker.
// No dependencies; included by the checker file.
`ifndef ALPHA8_BLEND_RGB565_BE_ASSERT_SVH
`define ALPHA8_BLEND_RGB565_BE_ASSERT_SVH

// Antecedent implies consequent in the same cycle (consequent may carry ##n).
`define A8B_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a8b check failed");

// Expression must hold at every clock edge out of reset.
`define A8B_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("a8b check failed");

`endif

// ----- design/a8b_pkg.sv -----
// Package for the alpha8_blend_rgb565_be block: widths, codes, shared types.
// No dependencies.
`timescale 1ns / 1ps

package a8b_pkg;

    localparam int COV_W    = 8;
    localparam int PIX_W    = 16;
    localparam int RB_W     = 5;
    localparam int G_W      = 6;
    localparam int SCALE_W  = 17;
    localparam int PROD_W   = 24;
    localparam int RECIP_W  = 25;
    localparam int MUL_W    = PROD_W + RECIP_W;
    localparam int CFG_IDX_W = 3;
    localparam int LATENCY  = 5;

    localparam logic [SCALE_W-1:0] FULL_ALPHA = 17'h10000;
    // floor(2^32 / 255)
    localparam logic [RECIP_W-1:0] RECIP_255 = 25'h1010101;

    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SCALE = 3'd3;

    typedef struct packed {
        logic [RB_W-1:0]    tint_red;
        logic [G_W-1:0]     tint_green;
        logic [RB_W-1:0]    tint_blue;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    typedef struct packed {
        logic [RB_W-1:0] hi;
        logic [G_W-1:0]  mid;
        logic [RB_W-1:0] lo;
    } pix_t;

endpackage

// ----- design/a8b_cfg.sv -----
// Configuration register file: tint channels and saturated alpha scale.
// Depends on a8b_pkg.
`timescale 1ns / 1ps

module a8b_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [a8b_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [a8b_pkg::SCALE_W-1:0]   cfg_data,
    output a8b_pkg::cfg_t                 cfg
);

    a8b_pkg::cfg_t cfg_reg;
    a8b_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                a8b_pkg::REG_TINT_RED:
                    cfg_next.tint_red = cfg_data[a8b_pkg::RB_W-1:0];
                a8b_pkg::REG_TINT_GREEN:
                    cfg_next.tint_green = cfg_data[a8b_pkg::G_W-1:0];
                a8b_pkg::REG_TINT_BLUE:
                    cfg_next.tint_blue = cfg_data[a8b_pkg::RB_W-1:0];
                a8b_pkg::REG_ALPHA_SCALE:
                    // saturate at full alpha on write
                    cfg_next.scale = (cfg_data > a8b_pkg::FULL_ALPHA) ?
                                     a8b_pkg::FULL_ALPHA : cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tint_red   <= 5'd31;
            cfg_reg.tint_green <= 6'd63;
            cfg_reg.tint_blue  <= 5'd31;
            cfg_reg.scale      <= a8b_pkg::FULL_ALPHA;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/a8b_alpha.sv -----
// Alpha stages: coverage * scale, divide by 255 via reciprocal and correction.
// Pixel unpack rides along. Depends on a8b_pkg.
`timescale 1ns / 1ps

module a8b_alpha
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [a8b_pkg::COV_W-1:0]     coverage,
    input  logic [a8b_pkg::PIX_W-1:0]     dest_pixel,
    input  logic [a8b_pkg::SCALE_W-1:0]   scale,
    output logic                          out_valid,
    output logic [a8b_pkg::SCALE_W-1:0]   alpha,
    output a8b_pkg::pix_t                 pix
);

    localparam int PW = a8b_pkg::PROD_W;
    localparam int MW = a8b_pkg::MUL_W;
    localparam int SW = a8b_pkg::SCALE_W;

    logic v1_reg, v2_reg, v3_reg;
    logic [PW-1:0] x1_reg, x2_reg;
    logic [MW-1:0] m2_reg;
    logic [SW-1:0] alpha3_reg;
    a8b_pkg::pix_t pix1_reg, pix2_reg, pix3_reg;

    logic [PW:0]   prod;
    logic [PW-1:0] x1_next;
    logic [MW-1:0] m2_next;
    logic [SW-1:0] q_est;
    logic [PW:0]   q_x255;
    logic [PW:0]   rem;
    logic [SW-1:0] alpha3_next;
    logic [a8b_pkg::PIX_W-1:0] swapped;
    a8b_pkg::pix_t pix1_next;

    always_comb
    begin
        prod    = {{(PW+1-a8b_pkg::COV_W){1'b0}}, coverage} * {{(PW+1-SW){1'b0}}, scale};
        x1_next = prod[PW-1:0];
        swapped = {dest_pixel[7:0], dest_pixel[15:8]};
        pix1_next.lo  = swapped[4:0];
        pix1_next.mid = swapped[10:5];
        pix1_next.hi  = swapped[15:11];
        m2_next = {{(MW-PW){1'b0}}, x1_reg} *
                  {{(MW-a8b_pkg::RECIP_W){1'b0}}, a8b_pkg::RECIP_255};
        // estimate is exact or one low
        q_est  = m2_reg[MW-1:32];
        q_x255 = {q_est, 8'd0} - {{(PW+1-SW){1'b0}}, q_est};
        rem    = {1'b0, x2_reg} - q_x255;
        alpha3_next = (rem >= (PW+1)'(255)) ? q_est + 1'b1 : q_est;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg     <= x1_next;
        pix1_reg   <= pix1_next;
        m2_reg     <= m2_next;
        x2_reg     <= x1_reg;
        pix2_reg   <= pix1_reg;
        alpha3_reg <= alpha3_next;
        pix3_reg   <= pix2_reg;
    end

    assign out_valid = v3_reg;
    assign alpha     = alpha3_reg;
    assign pix       = pix3_reg;

endmodule

// ----- design/a8b_mix.sv -----
// Mix stages: per-channel weighted products, then sum, shift, repack, byte swap.
// Depends on a8b_pkg.
`timescale 1ns / 1ps

module a8b_mix
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [a8b_pkg::SCALE_W-1:0]   alpha,
    input  a8b_pkg::pix_t                 pix,
    input  a8b_pkg::cfg_t                 cfg,
    output logic                          out_valid,
    output logic [a8b_pkg::PIX_W-1:0]     blended_pixel
);

    localparam int SW = a8b_pkg::SCALE_W;
    localparam int RW = a8b_pkg::RB_W;
    localparam int GW = a8b_pkg::G_W;
    localparam int PRW = SW + GW;

    logic v4_reg, v5_reg;
    logic [PRW-1:0] br_reg, tr_reg, bg_reg, tg_reg, bb_reg, tb_reg;
    logic [a8b_pkg::PIX_W-1:0] out_reg;

    logic [SW:0]    inv_wide;
    logic [SW-1:0]  inv;
    logic [PRW:0]   sum_r, sum_g, sum_b;
    logic [a8b_pkg::PIX_W-1:0] packed_px;

    always_comb
    begin
        inv_wide = {1'b0, a8b_pkg::FULL_ALPHA} + {1'b0, a8b_pkg::FULL_ALPHA}
                 - {1'b0, a8b_pkg::FULL_ALPHA} - {1'b0, alpha};
        inv      = inv_wide[SW-1:0];
        sum_r = {1'b0, br_reg} + {1'b0, tr_reg};
        sum_g = {1'b0, bg_reg} + {1'b0, tg_reg};
        sum_b = {1'b0, bb_reg} + {1'b0, tb_reg};
        packed_px = {sum_b[16 +: RW], sum_g[16 +: GW], sum_r[16 +: RW]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        br_reg  <= {{(PRW-RW){1'b0}}, pix.lo}  * {{(PRW-SW){1'b0}}, inv};
        tr_reg  <= {{(PRW-RW){1'b0}}, cfg.tint_red}   * {{(PRW-SW){1'b0}}, alpha};
        bg_reg  <= {{(PRW-GW){1'b0}}, pix.mid} * {{(PRW-SW){1'b0}}, inv};
        tg_reg  <= {{(PRW-GW){1'b0}}, cfg.tint_green} * {{(PRW-SW){1'b0}}, alpha};
        bb_reg  <= {{(PRW-RW){1'b0}}, pix.hi}  * {{(PRW-SW){1'b0}}, inv};
        tb_reg  <= {{(PRW-RW){1'b0}}, cfg.tint_blue}  * {{(PRW-SW){1'b0}}, alpha};
        out_reg <= {packed_px[7:0], packed_px[15:8]};
    end

    assign out_valid     = v5_reg;
    assign blended_pixel = out_reg;

endmodule

// ----- design/alpha8_blend_rgb565_be.sv -----
// Top level of the alpha8_blend_rgb565_be block: config registers and pipeline.
// Depends on a8b_pkg, a8b_cfg, a8b_alpha, a8b_mix.
//
// Usage:
//   Items: drive coverage and dest_pixel (byte-swapped RGB565) with start
//   high; an item is taken at each edge where start is high and busy low.
//   busy never rises, so one item can be taken every cycle.
//   Results: blended_pixel is valid for one cycle while done is high;
//   results leave in item order. The pipeline has five register stages:
//   product, reciprocal multiply, divide-by-255 correction, channel
//   multiplies, sum and repack.
//   Throughput: one item per cycle.
//   Config: cfg_valid with cfg_index/cfg_data writes a register at the
//   edge where cfg_ready is high (always); indexes above 3 are ignored.
//   alpha_scale values above 65536 are stored as 65536. Write config only
//   while no item is in flight.
//   Reset: rst_n low clears the pipeline (items in flight are dropped) and
//   loads white tint at full scale.
//   The receiver cannot stall; done is not held off.
`timescale 1ns / 1ps

module alpha8_blend_rgb565_be
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [a8b_pkg::COV_W-1:0]     coverage,
    input  logic [a8b_pkg::PIX_W-1:0]     dest_pixel,
    output logic                          done,
    output logic [a8b_pkg::PIX_W-1:0]     blended_pixel,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [a8b_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [a8b_pkg::SCALE_W-1:0]   cfg_data
);

    a8b_pkg::cfg_t cfg;
    a8b_pkg::pix_t pix;
    logic [a8b_pkg::SCALE_W-1:0] alpha;
    logic alpha_valid;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    a8b_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    a8b_alpha u_alpha
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .coverage   (coverage),
        .dest_pixel (dest_pixel),
        .scale      (cfg.scale),
        .out_valid  (alpha_valid),
        .alpha      (alpha),
        .pix        (pix)
    );

    a8b_mix u_mix
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (alpha_valid),
        .alpha         (alpha),
        .pix           (pix),
        .cfg           (cfg),
        .out_valid     (done),
        .blended_pixel (blended_pixel)
    );

endmodule

// ----- design/a8b_chk.sv -----
// Port-level checker for alpha8_blend_rgb565_be, bound to the top level.
// Depends on a8b_pkg and alpha8_blend_rgb565_be_assert.svh.
`timescale 1ns / 1ps
`include "alpha8_blend_rgb565_be_assert.svh"

module a8b_chk
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [a8b_pkg::COV_W-1:0]     coverage,
    input  logic [a8b_pkg::PIX_W-1:0]     dest_pixel,
    input  logic                          done,
    input  logic [a8b_pkg::PIX_W-1:0]     blended_pixel
);

    logic item_in;
    assign item_in = start && !busy;

    // every result traces back to an item taken a fixed latency earlier
    `A8B_ASSERT_IMPL(a_done_has_item, clk, rst_n, done, $past(item_in, a8b_pkg::LATENCY))

    // every item yields a result
    `A8B_ASSERT_IMPL(a_item_gives_done, clk, rst_n, item_in, ##(a8b_pkg::LATENCY) done)

    // zero coverage passes the pixel through unchanged
    `A8B_ASSERT_IMPL(a_zero_cov_pass, clk, rst_n, item_in && (coverage == '0), ##(a8b_pkg::LATENCY) (blended_pixel == $past(dest_pixel, a8b_pkg::LATENCY)))

    // no backpressure toward the sender
    `A8B_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

endmodule

bind alpha8_blend_rgb565_be a8b_chk u_a8b_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .coverage      (coverage),
    .dest_pixel    (dest_pixel),
    .done          (done),
    .blended_pixel (blended_pixel)
);

// ----- tb/sv/alpha8_blend_rgb565_be_test.sv -----
// Self-checking testbench for alpha8_blend_rgb565_be: per-pixel tint blending, register writes.
// Depends on a8b_pkg and the alpha8_blend_rgb565_be RTL; a scoreboard class predicts every pixel.
`timescale 1ns / 1ps

module alpha8_blend_rgb565_be_test;

    class blend_board;
        logic [a8b_pkg::RB_W-1:0]    red;
        logic [a8b_pkg::G_W-1:0]     green;
        logic [a8b_pkg::RB_W-1:0]    blue;
        logic [a8b_pkg::SCALE_W-1:0] scale;
        logic [a8b_pkg::PIX_W-1:0]   expected_q[$];
        int                          errors;
        int                          checked;
        int                          noted;

        function new();
            red = 5'd31;
            green = 6'd63;
            blue = 5'd31;
            scale = a8b_pkg::FULL_ALPHA;
            errors = 0;
            checked = 0;
            noted = 0;
        endfunction

        function void write_reg(logic [a8b_pkg::CFG_IDX_W-1:0] idx,
                                logic [a8b_pkg::SCALE_W-1:0] data);
            case (idx)
                a8b_pkg::REG_TINT_RED:    red = data[a8b_pkg::RB_W-1:0];
                a8b_pkg::REG_TINT_GREEN:  green = data[a8b_pkg::G_W-1:0];
                a8b_pkg::REG_TINT_BLUE:   blue = data[a8b_pkg::RB_W-1:0];
                a8b_pkg::REG_ALPHA_SCALE: scale = data;
                default: ;
            endcase
        endfunction

        function int unsigned mix(int unsigned back, int unsigned tint, int unsigned alpha);
            return (back * (32'd65536 - alpha) + tint * alpha) >> 16;
        endfunction

        function logic [a8b_pkg::PIX_W-1:0] blend(logic [a8b_pkg::COV_W-1:0] cov,
                                                  logic [a8b_pkg::PIX_W-1:0] word);
            a8b_pkg::pix_t             p;
            a8b_pkg::pix_t             q;
            int unsigned               s;
            int unsigned               alpha;
            int unsigned               lo;
            int unsigned               mid;
            int unsigned               hi;
            logic [a8b_pkg::PIX_W-1:0] packed_word;
            p = {word[7:0], word[15:8]};
            s = (scale > a8b_pkg::FULL_ALPHA) ? 32'(a8b_pkg::FULL_ALPHA) : 32'(scale);
            alpha = (32'(cov) * s) / 255;
            lo = mix(32'(p.lo), 32'(red), alpha);
            mid = mix(32'(p.mid), 32'(green), alpha);
            hi = mix(32'(p.hi), 32'(blue), alpha);
            q.lo = lo[a8b_pkg::RB_W-1:0];
            q.mid = mid[a8b_pkg::G_W-1:0];
            q.hi = hi[a8b_pkg::RB_W-1:0];
            packed_word = q;
            return {packed_word[7:0], packed_word[15:8]};
        endfunction

        function void note_item(logic [a8b_pkg::COV_W-1:0] cov,
                                logic [a8b_pkg::PIX_W-1:0] word);
            expected_q.push_back(blend(cov, word));
            noted++;
        endfunction

        function void check_pixel(logic [a8b_pkg::PIX_W-1:0] actual);
            logic [a8b_pkg::PIX_W-1:0] want;
            checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result %h arrived with nothing expected", $realtime, actual);
                return;
            end
            want = expected_q.pop_front();
            if (actual !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: blended_pixel expected %h actual %h", $realtime, want, actual);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flush();
            if (expected_q.size() != 0)
            begin
                errors += expected_q.size();
                $display("%0d expected results never arrived", expected_q.size());
                expected_q.delete();
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [a8b_pkg::COV_W-1:0]     coverage;
    logic [a8b_pkg::PIX_W-1:0]     dest_pixel;
    logic                          done;
    logic [a8b_pkg::PIX_W-1:0]     blended_pixel;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [a8b_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [a8b_pkg::SCALE_W-1:0]   cfg_data;

    blend_board board = new();
    int settings = 0;

    alpha8_blend_rgb565_be uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .coverage      (coverage),
        .dest_pixel    (dest_pixel),
        .done          (done),
        .blended_pixel (blended_pixel),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_pixel(blended_pixel);
            if (start && !busy)
                board.note_item(coverage, dest_pixel);
        end
    end

    task automatic send_item(input logic [a8b_pkg::COV_W-1:0] cov,
                             input logic [a8b_pkg::PIX_W-1:0] word);
        @(negedge clk);
        start <= 1'b1;
        coverage <= cov;
        dest_pixel <= word;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            coverage <= (a8b_pkg::COV_W)'($urandom);
            dest_pixel <= (a8b_pkg::PIX_W)'($urandom);
        end
    endtask

    task automatic write_reg(input logic [a8b_pkg::CFG_IDX_W-1:0] idx,
                             input logic [a8b_pkg::SCALE_W-1:0] data);
        @(negedge clk);
        start <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every pixel in flight has come back
    task automatic quiesce();
        @(negedge clk);
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (a8b_pkg::LATENCY + 2) @(posedge clk);
    endtask

    task automatic random_pixels(input int n);
        int sent;
        int burst;
        logic [a8b_pkg::COV_W-1:0] cov;
        sent = 0;
        while (sent < n)
        begin
            burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            while (burst > 0 && sent < n)
            begin
                case ($urandom_range(0, 7))
                    0:       cov = '0;
                    1:       cov = '1;
                    default: cov = (a8b_pkg::COV_W)'($urandom);
                endcase
                send_item(cov, (a8b_pkg::PIX_W)'($urandom));
                sent++;
                burst--;
            end
            idle_cycles($urandom_range(0, 6));
        end
    endtask

    initial
    begin
        logic [a8b_pkg::SCALE_W-1:0] s;
        rst_n = 1'b0;
        start = 1'b0;
        coverage = '0;
        dest_pixel = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // white tint at full scale straight out of reset
        settings++;
        send_item(8'd0, 16'h0000);
        send_item(8'd255, 16'h0000);
        send_item(8'd255, 16'hFFFF);
        send_item(8'd0, 16'hFFFF);
        send_item(8'd1, 16'hAAAA);
        send_item(8'd128, 16'h5555);
        idle_cycles(2);
        send_item(8'd254, 16'h00FF);
        send_item(8'd127, 16'hFF00);
        send_item(8'd85, 16'h1234);

        // zero tint, zero scale: pixel passes through
        quiesce();
        write_reg(a8b_pkg::REG_TINT_RED, '0);
        write_reg(a8b_pkg::REG_TINT_GREEN, '0);
        write_reg(a8b_pkg::REG_TINT_BLUE, '0);
        write_reg(a8b_pkg::REG_ALPHA_SCALE, '0);
        settings++;
        send_item(8'd255, 16'hFFFF);
        send_item(8'd128, 16'hA5A5);
        send_item(8'd255, 16'h0000);

        // all-ones data: tints masked, scale saturates; unknown indexes ignored
        quiesce();
        write_reg(a8b_pkg::REG_TINT_RED, '1);
        write_reg(a8b_pkg::REG_TINT_GREEN, '1);
        write_reg(a8b_pkg::REG_TINT_BLUE, '1);
        write_reg(a8b_pkg::REG_ALPHA_SCALE, '1);
        for (int k = int'(a8b_pkg::REG_ALPHA_SCALE) + 1; k < 2 ** a8b_pkg::CFG_IDX_W; k++)
        begin
            write_reg((a8b_pkg::CFG_IDX_W)'(k), '0);
            write_reg((a8b_pkg::CFG_IDX_W)'(k), '1);
        end
        settings++;
        send_item(8'd255, 16'h0000);
        send_item(8'd1, 16'h0000);
        send_item(8'd254, 16'hFFFF);
        send_item(8'd128, 16'h1F3E);

        // tinted kernel, alpha scale 4080
        quiesce();
        write_reg(a8b_pkg::REG_TINT_RED, 17'd10);
        write_reg(a8b_pkg::REG_TINT_GREEN, 17'd40);
        write_reg(a8b_pkg::REG_TINT_BLUE, 17'd3);
        write_reg(a8b_pkg::REG_ALPHA_SCALE, 17'd4080);
        settings++;
        send_item(8'd255, 16'hFFFF);
        send_item(8'd255, 16'h0000);
        send_item(8'd100, 16'h7E0F);

        quiesce();
        write_reg(a8b_pkg::REG_ALPHA_SCALE, 17'd1);
        settings++;
        send_item(8'd255, 16'hFFFF);

        for (int ph = 0; ph < 6; ph++)
        begin
            quiesce();
            write_reg(a8b_pkg::REG_TINT_RED, (a8b_pkg::SCALE_W)'($urandom));
            write_reg(a8b_pkg::REG_TINT_GREEN, (a8b_pkg::SCALE_W)'($urandom));
            write_reg(a8b_pkg::REG_TINT_BLUE, (a8b_pkg::SCALE_W)'($urandom));
            case (ph % 5)
                0:       s = (a8b_pkg::SCALE_W)'(16 * $urandom_range(0, 255));
                1:       s = a8b_pkg::FULL_ALPHA;
                2:       s = (a8b_pkg::SCALE_W)'($urandom_range(0, 65536));
                3:       s = (a8b_pkg::SCALE_W)'($urandom_range(65537, 131071));
                default: s = (a8b_pkg::SCALE_W)'(16 * $urandom_range(0, 255));
            endcase
            write_reg(a8b_pkg::REG_ALPHA_SCALE, s);
            if (ph == 5)
                write_reg((a8b_pkg::CFG_IDX_W)'($urandom_range(
                              int'(a8b_pkg::REG_ALPHA_SCALE) + 1,
                              2 ** a8b_pkg::CFG_IDX_W - 1)),
                          (a8b_pkg::SCALE_W)'($urandom));
            settings++;
            random_pixels(100);
        end

        quiesce();
        board.flush();
        $display("blended %0d pixels under %0d register settings", board.noted, settings);
        $display("%0d results compared, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0)
            $display("alpha8_blend_rgb565_be_test passed");
        else
            $display("alpha8_blend_rgb565_be_test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout waiting for the block");
        $display("alpha8_blend_rgb565_be_test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/a8b_pkg.sv
design/a8b_cfg.sv
design/a8b_alpha.sv
design/a8b_mix.sv
design/alpha8_blend_rgb565_be.sv
design/a8b_chk.sv
tb/sv/alpha8_blend_rgb565_be_test.sv
